// ===== rtl/char_lcd_nibble_sequencer_unit_assert.svh =====
// Assertion macros for the character LCD sequencer controller
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// condition must hold on every clock edge outside reset
`define CLNS_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define CLNS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLNS_ASSERT(name, cond, msg)
`define CLNS_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== rtl/clns_pkg.sv =====
// Types, codes and helper functions of the character LCD nibble sequencer
package clns_pkg;

  // host command codes
  typedef enum logic [3:0] {
    CMD_INIT   = 4'd0,
    CMD_INSTR  = 4'd1,
    CMD_DATA   = 4'd2,
    CMD_CLEAR  = 4'd3,
    CMD_HOME   = 4'd4,
    CMD_DDRAM  = 4'd5,
    CMD_CGRAM  = 4'd6,
    CMD_CURSOR = 4'd7,
    CMD_BLINK  = 4'd8
  } clns_cmd_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_EDGE_WAIT     = 2'd0,
    REG_COMMAND_WAIT  = 2'd1,
    REG_CLEAR_WAIT    = 2'd2,
    REG_POWER_UP_WAIT = 2'd3
  } clns_reg_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_BYTE
  } clns_state_e;

  // pin-state phases within one byte
  localparam logic [2:0] PH_MODE   = 3'd0;
  localparam logic [2:0] PH_EN_HI1 = 3'd1;
  localparam logic [2:0] PH_UPPER  = 3'd2;
  localparam logic [2:0] PH_EN_LO1 = 3'd3;
  localparam logic [2:0] PH_EN_HI2 = 3'd4;
  localparam logic [2:0] PH_LOWER  = 3'd5;
  localparam logic [2:0] PH_EN_LO2 = 3'd6;

  // phases of the init preamble
  localparam logic [2:0] PRE_PWR   = 3'd0;
  localparam logic [2:0] PRE_EN_HI = 3'd1;
  localparam logic [2:0] PRE_NIB   = 3'd2;
  localparam logic [2:0] PRE_EN_LO = 3'd3;

  localparam logic [1:0] INIT_LAST_BYTE = 2'd3;

  // instruction bytes
  localparam logic [7:0] INS_FUNC_SET  = 8'h28;
  localparam logic [7:0] INS_DISP_INIT = 8'h0C;
  localparam logic [7:0] INS_ENTRY     = 8'h06;
  localparam logic [7:0] INS_CLEAR     = 8'h01;
  localparam logic [7:0] INS_HOME      = 8'h02;
  localparam logic [7:0] INS_CGRAM     = 8'h40;
  localparam logic [7:0] INS_DDRAM     = 8'h80;
  localparam logic [7:0] INS_DISP_CTRL = 8'h08;
  localparam logic [3:0] HALF_FUNC_SET = 4'h2;
  localparam logic [2:0] DC_RESET      = 3'b100;

  localparam logic [7:0]  EDGE_WAIT_RST     = 8'd2;
  localparam logic [11:0] COMMAND_WAIT_RST  = 12'd100;
  localparam logic [13:0] CLEAR_WAIT_RST    = 14'd3000;
  localparam logic [15:0] POWER_UP_WAIT_RST = 16'd50000;

  // controller to datapath commands
  typedef struct packed {
    logic       load;       // latch a new host word
    logic       emit;       // produce one pin state
    logic       pre;        // step belongs to the init preamble
    logic [2:0] phase;
    logic       init_load;  // load the next init byte
    logic [1:0] init_idx;
    logic       last;
  } clns_ctrl_t;

  // datapath status back to the controller
  typedef struct packed {
    logic slot_free;
  } clns_stat_t;

  // fixed byte sequence after the init preamble
  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = INS_FUNC_SET;
      2'd1:    b = INS_DISP_INIT;
      2'd2:    b = INS_CLEAR;
      default: b = INS_ENTRY;
    endcase
    return b;
  endfunction

  // saturate a hold sum into 1..65535
  function automatic logic [15:0] hold_clamp(input logic [16:0] s);
    logic [15:0] h;
    if (s[16])              h = 16'hFFFF;
    else if (s[15:0] == '0) h = 16'd1;
    else                    h = s[15:0];
    return h;
  endfunction

endpackage

// ===== rtl/clns_if.sv =====
// Handshake interfaces: host command word, pin-state word, config write
interface clns_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [7:0] byte_value;
  logic [6:0] ddram_address;
  logic [2:0] glyph_index;
  logic [2:0] glyph_row;
  modport source (output valid, command, byte_value, ddram_address, glyph_index,
                  glyph_row, input ready);
  modport sink   (input valid, command, byte_value, ddram_address, glyph_index,
                  glyph_row, output ready);
endinterface

interface clns_out_if;
  logic        valid;
  logic        ready;
  logic        register_select;
  logic        read_write;
  logic        enable_pin;
  logic [3:0]  data_nibble;
  logic [15:0] hold_cycles;
  logic        last;
  modport source (output valid, register_select, read_write, enable_pin, data_nibble,
                  hold_cycles, last, input ready);
  modport sink   (input valid, register_select, read_write, enable_pin, data_nibble,
                  hold_cycles, last, output ready);
endinterface

interface clns_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/clns_ctrl.sv =====
// Sequencing state machine: walks preamble and byte phases of a command
`include "char_lcd_nibble_sequencer_unit_assert.svh"
module clns_ctrl
  import clns_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [3:0] in_command_i,
  output logic       in_ready_o,
  input  clns_stat_t stat_i,
  output clns_ctrl_t ctrl_o
);

  clns_state_e state_q, state_d;
  logic [2:0]  phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic        init_q, init_d;
  logic        accept, known, emit, seq_end;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign known      = (in_command_i <= CMD_BLINK);
  assign emit       = (state_q != ST_IDLE) && stat_i.slot_free;
  assign seq_end    = !init_q || (idx_q == INIT_LAST_BYTE);

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    init_d  = init_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && known) begin
          phase_d = PH_MODE;
          idx_d   = '0;
          init_d  = (in_command_i == CMD_INIT);
          state_d = (in_command_i == CMD_INIT) ? ST_PRE : ST_BYTE;
        end
      end
      ST_PRE: begin
        if (emit) begin
          if (phase_q == PRE_EN_LO) begin
            state_d = ST_BYTE;
            phase_d = PH_MODE;
          end else begin
            phase_d = phase_q + 3'd1;
          end
        end
      end
      ST_BYTE: begin
        if (emit) begin
          if (phase_q == PH_EN_LO2) begin
            phase_d = PH_MODE;
            if (seq_end) state_d = ST_IDLE;
            else         idx_d   = idx_q + 2'd1;
          end else begin
            phase_d = phase_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.load      = accept && known;
    ctrl_o.emit      = emit;
    ctrl_o.pre       = (state_q == ST_PRE);
    ctrl_o.phase     = phase_q;
    ctrl_o.init_idx  = idx_q;
    ctrl_o.last      = (state_q == ST_BYTE) && (phase_q == PH_EN_LO2) && seq_end;
    unique case (state_q)
      ST_PRE: begin
        ctrl_o.init_load = emit && (phase_q == PRE_EN_LO);
        ctrl_o.init_idx  = '0;
      end
      ST_BYTE: begin
        ctrl_o.init_load = emit && (phase_q == PH_EN_LO2) && !seq_end;
        ctrl_o.init_idx  = idx_q + 2'd1;
      end
      default: ctrl_o.init_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_MODE;
      idx_q   <= '0;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      init_q  <= init_d;
    end
  end

  `CLNS_ASSERT_NEXT(a_last_ends, ctrl_o.emit && ctrl_o.last, state_q == ST_IDLE, "last word did not end the command")
  `CLNS_ASSERT(a_pre_is_init, (state_q != ST_PRE) || init_q, "preamble outside init")
  `CLNS_ASSERT(a_phase_range, phase_q <= PH_EN_LO2, "phase counter out of range")
  `CLNS_ASSERT_NEXT(a_stall_holds, (state_q != ST_IDLE) && !stat_i.slot_free, $stable(phase_q) && $stable(idx_q), "sequence advanced while stalled")

endmodule

// ===== rtl/clns_dp.sv =====
// Datapath: timing registers, pin levels, hold arithmetic, output register
module clns_dp
  import clns_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  clns_in_if.sink    in_i,
  clns_cfg_if.sink   cfg_i,
  clns_out_if.source out_o,
  input  clns_ctrl_t ctrl_i,
  output clns_stat_t stat_o
);

  logic [7:0]  edge_q;
  logic [11:0] cmdw_q;
  logic [13:0] clrw_q;
  logic [15:0] pwrw_q;
  logic        en_q, en_d, sel_q, sel_d;
  logic [3:0]  nib_q, nib_d;
  logic [2:0]  dc_q, dc_d;
  logic [7:0]  byte_q, byte_d;
  logic        rs_q, rs_d, clr_q, clr_d;
  logic        out_valid_q;
  logic        out_sel_q, out_en_q, out_last_q;
  logic [3:0]  out_nib_q;
  logic [15:0] out_hold_q;
  logic [16:0] e1, e2, post, hold_a, hold_b;

  assign cfg_i.ready = 1'b1;
  assign stat_o.slot_free = !out_valid_q || out_o.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= EDGE_WAIT_RST;
      cmdw_q <= COMMAND_WAIT_RST;
      clrw_q <= CLEAR_WAIT_RST;
      pwrw_q <= POWER_UP_WAIT_RST;
    end else if (cfg_i.valid) begin
      unique case (clns_reg_e'(cfg_i.index))
        REG_EDGE_WAIT:     edge_q <= cfg_i.data[7:0];
        REG_COMMAND_WAIT:  cmdw_q <= cfg_i.data[11:0];
        REG_CLEAR_WAIT:    clrw_q <= cfg_i.data[13:0];
        REG_POWER_UP_WAIT: pwrw_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // byte, mode and post-wait selection for a new word or the next init byte
  always_comb begin
    dc_d   = dc_q;
    byte_d = byte_q;
    rs_d   = rs_q;
    clr_d  = clr_q;
    if (ctrl_i.load) begin
      rs_d  = 1'b0;
      clr_d = 1'b0;
      unique case (clns_cmd_e'(in_i.command))
        CMD_INIT:   dc_d = DC_RESET;
        CMD_INSTR:  byte_d = in_i.byte_value;
        CMD_DATA: begin
          byte_d = in_i.byte_value;
          rs_d   = 1'b1;
        end
        CMD_CLEAR: begin
          byte_d = INS_CLEAR;
          clr_d  = 1'b1;
        end
        CMD_HOME: begin
          byte_d = INS_HOME;
          clr_d  = 1'b1;
        end
        CMD_DDRAM:  byte_d = INS_DDRAM | {1'b0, in_i.ddram_address};
        CMD_CGRAM:  byte_d = INS_CGRAM | {2'b00, in_i.glyph_index, in_i.glyph_row};
        CMD_CURSOR: begin
          dc_d   = dc_q ^ 3'b010;
          byte_d = INS_DISP_CTRL | {5'b0, dc_d};
        end
        CMD_BLINK: begin
          dc_d   = dc_q ^ 3'b001;
          byte_d = INS_DISP_CTRL | {5'b0, dc_d};
        end
        default: ;
      endcase
    end else if (ctrl_i.init_load) begin
      byte_d = init_byte(ctrl_i.init_idx);
      rs_d   = 1'b0;
      clr_d  = (byte_d == INS_CLEAR);
    end
  end

  // pin levels after this step
  always_comb begin
    en_d  = en_q;
    nib_d = nib_q;
    sel_d = sel_q;
    if (ctrl_i.pre) begin
      case (ctrl_i.phase)
        PRE_PWR: begin
          en_d  = 1'b0;
          nib_d = '0;
          sel_d = 1'b0;
        end
        PRE_EN_HI: en_d  = 1'b1;
        PRE_NIB:   nib_d = HALF_FUNC_SET;
        default:   en_d  = 1'b0;
      endcase
    end else begin
      case (ctrl_i.phase)
        PH_MODE:   sel_d = rs_q;
        PH_EN_HI1: en_d  = 1'b1;
        PH_UPPER:  nib_d = byte_q[7:4];
        PH_EN_LO1: en_d  = 1'b0;
        PH_EN_HI2: en_d  = 1'b1;
        PH_LOWER:  nib_d = byte_q[3:0];
        default:   en_d  = 1'b0;
      endcase
    end
  end

  // hold time operands
  assign e1   = {9'b0, edge_q};
  assign e2   = {8'b0, edge_q, 1'b0};
  assign post = clr_q ? {3'b0, clrw_q} : {5'b0, cmdw_q};

  always_comb begin
    hold_a = e1;
    hold_b = '0;
    if (ctrl_i.pre) begin
      case (ctrl_i.phase)
        PRE_PWR: begin
          hold_a = {1'b0, pwrw_q};
          hold_b = e2;
        end
        PRE_EN_LO: hold_b = {5'b0, cmdw_q};
        default: ;
      endcase
    end else begin
      case (ctrl_i.phase)
        PH_MODE, PH_EN_LO1: hold_a = e2;
        PH_EN_LO2:          hold_b = post;
        default: ;
      endcase
    end
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      nib_q <= '0;
      sel_q <= 1'b0;
      dc_q  <= DC_RESET;
      rs_q  <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      dc_q  <= dc_d;
      rs_q  <= rs_d;
      clr_q <= clr_d;
      if (ctrl_i.emit) begin
        en_q  <= en_d;
        nib_q <= nib_d;
        sel_q <= sel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_sel_q  <= sel_d;
      out_en_q   <= en_d;
      out_nib_q  <= nib_d;
      out_hold_q <= hold_clamp(hold_a + hold_b);
      out_last_q <= ctrl_i.last;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.register_select = out_sel_q;
  assign out_o.read_write      = 1'b0;
  assign out_o.enable_pin      = out_en_q;
  assign out_o.data_nibble     = out_nib_q;
  assign out_o.hold_cycles     = out_hold_q;
  assign out_o.last            = out_last_q;

endmodule

// ===== rtl/char_lcd_nibble_sequencer_unit.sv =====
// Top level of the character LCD 4-bit nibble sequencer
//
// Takes one command word on in_i and expands it into a run of LCD pin-state
// words on out_o (RS, R/W, E, D7..D4 and a hold time in cycles); the final
// word of each command has last set. cfg_i writes the four timing registers
// (edge, command, clear and power-up waits); it is always ready and should
// only be written while the block is idle.
// Command flow: a word is accepted only while the sequencer is idle; its pin
// states then go to the output register one per cycle while the receiver
// does not stall. A byte command is 7 pin states; init is 32 pin states.
// The phase counter of the controller steps once per emitted state. Unknown
// command codes are accepted and produce nothing.
// Receiver stall: the output register holds its word until out_o.ready; the
// sequence freezes meanwhile and resumes without loss.
// Reset: timing registers return to 2/100/3000/50000, pins levels to low,
// display control to display on, cursor and blink off.
module char_lcd_nibble_sequencer_unit
  import clns_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  clns_in_if.sink    in_i,
  clns_cfg_if.sink   cfg_i,
  clns_out_if.source out_o
);

  clns_ctrl_t ctrl;
  clns_stat_t stat;

  clns_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .stat_i       (stat),
    .ctrl_o       (ctrl)
  );

  clns_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .out_o  (out_o),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

endmodule
